// ===== hdl/lba_to_chs_encoder_defines.svh =====
`ifndef LBA_TO_CHS_ENCODER_DEFINES_SVH
`define LBA_TO_CHS_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define LTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define LTC_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== hdl/ltc_pkg.sv =====
package ltc_pkg;

  localparam int unsigned LBA_WIDTH_DEF = 32;

  localparam int unsigned HEAD_W  = 8;
  localparam int unsigned SPT_W   = 6;
  localparam int unsigned SPC_W   = HEAD_W + SPT_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CYL_W   = 32;
  localparam int unsigned CYL_PACKED_W = 10;

  localparam logic [HEAD_W-1:0] HEAD_RESET = 8'd64;
  localparam logic [SPT_W-1:0]  SPT_RESET  = 6'd32;
  localparam logic [SPC_W-1:0]  SPC_RESET  = 14'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_COUNT        = 2'd0,
    REG_SECTORS_PER_TRACK = 2'd1
  } cfg_reg_e;

endpackage

// ===== hdl/lba_to_chs_encoder.sv =====
// LBA to CHS encoder. Accepts one logical block address per clock (busy_o never rises)
// and returns the cylinder/head/sector triple in partition-table byte form, plus the
// full cylinder and an overflow flag. The address passes through an LBA_WIDTH-stage
// restoring divider by heads*sectors, one quotient bit per pipeline stage, then a
// 14-stage divider by sectors per track and an output register. valid_o is a one-cycle
// strobe; the receiver cannot stall it.
// Every stage reads the geometry registers directly, so a configuration write applies
// from the address accepted at the same edge and must only be made while no
// transaction is in flight; cfg_ready_o is always high. A register value of zero
// acts as one.
`include "lba_to_chs_encoder_defines.svh"

module lba_to_chs_encoder import ltc_pkg::*; #(
  parameter int unsigned LBA_WIDTH = LBA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [LBA_WIDTH-1:0]  lba_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  valid_o,
  output logic [7:0]            head_byte_o,
  output logic [7:0]            sector_cyl_high_byte_o,
  output logic [7:0]            cyl_low_byte_o,
  output logic [CYL_W-1:0]      cylinder_o,
  output logic                  cyl_overflow_o
);

  localparam int unsigned W   = LBA_WIDTH;
  localparam int unsigned BN  = SPC_W;
  localparam int unsigned LAT = W + BN + 3;

  // Configuration
  logic [HEAD_W-1:0] heads_q;
  logic [SPT_W-1:0]  spt_q;
  logic [SPC_W-1:0]  spc_q;
  logic [HEAD_W-1:0] head_wr;
  logic [SPT_W-1:0]  spt_wr;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign head_wr = (cfg_data_i == '0) ? HEAD_W'(1) : cfg_data_i;
  assign spt_wr  = (cfg_data_i[SPT_W-1:0] == '0) ? SPT_W'(1) : cfg_data_i[SPT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heads_q <= HEAD_RESET;
      spt_q   <= SPT_RESET;
      spc_q   <= SPC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HEAD_COUNT: begin
          heads_q <= head_wr;
          spc_q   <= SPC_W'(head_wr * spt_q);
        end
        REG_SECTORS_PER_TRACK: begin
          spt_q <= spt_wr;
          spc_q <= SPC_W'(heads_q * spt_wr);
        end
        default: ;
      endcase
    end
  end

  // Divider by sectors per cylinder: stage k holds k quotient bits
  logic             a_v_q [W+1];
  logic [SPC_W-1:0] a_r_q [W+1];
  logic [W-1:0]     a_x_q [W+1];
  logic [SPC_W-1:0] a_r_d [W+1];
  logic [W-1:0]     a_x_d [W+1];

  // Divider by sectors per track, cylinder carried along
  logic             b_v_q   [BN+1];
  logic [SPT_W-1:0] b_r_q   [BN+1];
  logic [BN-1:0]    b_x_q   [BN+1];
  logic [W-1:0]     b_cyl_q [BN+1];
  logic [SPT_W-1:0] b_r_d   [BN+1];
  logic [BN-1:0]    b_x_d   [BN+1];

  always_comb begin
    logic [SPC_W:0] rs;
    logic [SPC_W:0] diff;
    logic           ge;
    logic [SPT_W:0] rs2;
    logic [SPT_W:0] diff2;
    logic           ge2;
    rs    = '0;
    diff  = '0;
    ge    = 1'b0;
    rs2   = '0;
    diff2 = '0;
    ge2   = 1'b0;
    a_r_d[0] = '0;
    a_x_d[0] = lba_i;
    for (int k = 1; k <= W; k++) begin
      rs       = {a_r_q[k-1], a_x_q[k-1][W-1]};
      diff     = rs - {1'b0, spc_q};
      ge       = (rs >= {1'b0, spc_q});
      a_r_d[k] = ge ? diff[SPC_W-1:0] : rs[SPC_W-1:0];
      a_x_d[k] = {a_x_q[k-1][W-2:0], ge};
    end
    b_r_d[0] = '0;
    b_x_d[0] = a_r_q[W];
    for (int k = 1; k <= BN; k++) begin
      rs2      = {b_r_q[k-1], b_x_q[k-1][BN-1]};
      diff2    = rs2 - {1'b0, spt_q};
      ge2      = (rs2 >= {1'b0, spt_q});
      b_r_d[k] = ge2 ? diff2[SPT_W-1:0] : rs2[SPT_W-1:0];
      b_x_d[k] = {b_x_q[k-1][BN-2:0], ge2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= W; k++) begin
        a_v_q[k] <= 1'b0;
      end
      for (int k = 0; k <= BN; k++) begin
        b_v_q[k] <= 1'b0;
      end
    end else begin
      a_v_q[0] <= start_i && !busy_o;
      for (int k = 1; k <= W; k++) begin
        a_v_q[k] <= a_v_q[k-1];
      end
      b_v_q[0] <= a_v_q[W];
      for (int k = 1; k <= BN; k++) begin
        b_v_q[k] <= b_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= W; k++) begin
      a_r_q[k] <= a_r_d[k];
      a_x_q[k] <= a_x_d[k];
    end
    b_cyl_q[0] <= a_x_q[W];
    for (int k = 0; k <= BN; k++) begin
      b_r_q[k] <= b_r_d[k];
      b_x_q[k] <= b_x_d[k];
    end
    for (int k = 1; k <= BN; k++) begin
      b_cyl_q[k] <= b_cyl_q[k-1];
    end
  end

  // Output register
  logic [63:0]      cyl_wide;
  logic [SPT_W-1:0] sect;
  logic             valid_q;
  logic [7:0]       head_q;
  logic [7:0]       sch_q;
  logic [7:0]       cyl_low_q;
  logic [CYL_W-1:0] cyl_q;
  logic             ovf_q;

  assign cyl_wide = 64'(b_cyl_q[BN]);
  assign sect     = b_r_q[BN] + SPT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= b_v_q[BN];
    end
  end

  always_ff @(posedge clk_i) begin
    head_q    <= b_x_q[BN][7:0];
    sch_q     <= {cyl_wide[9:8], sect};
    cyl_low_q <= cyl_wide[7:0];
    cyl_q     <= cyl_wide[CYL_W-1:0];
    ovf_q     <= |b_cyl_q[BN][W-1:CYL_PACKED_W];
  end

  assign valid_o                = valid_q;
  assign head_byte_o            = head_q;
  assign sector_cyl_high_byte_o = sch_q;
  assign cyl_low_byte_o         = cyl_low_q;
  assign cylinder_o             = cyl_q;
  assign cyl_overflow_o         = ovf_q;

  `LTC_ASSERT_DELAY(a_latency, start_i && !busy_o, LAT, valid_o, "result missing after latency")
  `LTC_ASSERT_IMPL(a_no_spurious, valid_o, $past(start_i && !busy_o, LAT), "result without transaction")
  `LTC_ASSERT_IMPL(a_sector_nonzero, valid_o, sector_cyl_high_byte_o[5:0] != 6'd0, "sector is zero")

endmodule

// ===== dv/tb_lba_to_chs_encoder.sv =====
module tb_lba_to_chs_encoder import ltc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LATENCY        = 32 + 17;
  localparam int          CYCLE_LIMIT    = 250000;
  localparam int          RAND_PHASES    = 8;
  localparam int          ITEMS_PER_PH   = 240;
  localparam logic [63:0] CYL_PACKED_MAX = 64'd1023;

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [7:0]       head;
    logic [7:0]       sect_cyl_hi;
    logic [7:0]       cyl_lo;
    logic [CYL_W-1:0] cyl;
    logic             ovf;
  } chs_t;

  typedef enum logic {ROW_LBA, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [31:0]           lba;
    logic                  typed;
    chs_t                  want;
  } row_t;

  localparam int N_DIR = 30;
  localparam row_t DIR_ROWS [N_DIR] = '{
    // reset geometry: 64 heads, 32 sectors
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h0000_0000, 1'b1,
      '{8'd0, 8'h01, 8'h00, 32'h0000_0000, 1'b0}},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'hFFFF_FFFF, 1'b1,
      '{8'd63, 8'hE0, 8'hFF, 32'h001F_FFFF, 1'b1}},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h001F_FFFF, 1'b1,
      '{8'd63, 8'hE0, 8'hFF, 32'h0000_03FF, 1'b0}},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h0020_0000, 1'b1,
      '{8'd0, 8'h01, 8'h00, 32'h0000_0400, 1'b1}},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd31,         1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd32,         1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd2047,       1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h8000_0000, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h5555_5555, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'hAAAA_AAAA, 1'b0, '0},
    // zero registers act as one
    '{ROW_CFG, REG_HEAD_COUNT,        8'h00, 32'h0, 1'b0, '0},
    '{ROW_CFG, REG_SECTORS_PER_TRACK, 8'h00, 32'h0, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd0,          1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd1023,       1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd1024,       1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'hFFFF_FFFF, 1'b0, '0},
    // largest geometry; upper data bits of the sector write are dropped
    '{ROW_CFG, REG_HEAD_COUNT,        8'hFF, 32'h0, 1'b0, '0},
    '{ROW_CFG, REG_SECTORS_PER_TRACK, 8'hFF, 32'h0, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd16064,      1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd16063,      1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h00FA_FFFF, 1'b0, '0},
    // out-of-range register index
    '{ROW_CFG, REG_SPARE_2, 8'h01, 32'h0, 1'b0, '0},
    '{ROW_CFG, REG_SPARE_3, 8'h02, 32'h0, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'h1234_5678, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'hFFFF_FFFF, 1'b0, '0},
    // one sector per cylinder
    '{ROW_CFG, REG_HEAD_COUNT,        8'h01, 32'h0, 1'b0, '0},
    '{ROW_CFG, REG_SECTORS_PER_TRACK, 8'h01, 32'h0, 1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd1023,       1'b0, '0},
    '{ROW_LBA, REG_HEAD_COUNT, 8'h00, 32'd1024,       1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [31:0]           lba_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  valid_o;
  logic [7:0]            head_byte_o;
  logic [7:0]            sector_cyl_high_byte_o;
  logic [7:0]            cyl_low_byte_o;
  logic [CYL_W-1:0]      cylinder_o;
  logic                  cyl_overflow_o;

  chs_t        pending_chs[$];
  logic [7:0]  head_count_q;
  logic [5:0]  spt_q;
  int          mismatches;
  int unsigned cycles;

  lba_to_chs_encoder u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .lba_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .valid_o,
    .head_byte_o,
    .sector_cyl_high_byte_o,
    .cyl_low_byte_o,
    .cylinder_o,
    .cyl_overflow_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] nz(logic [63:0] v);
    return (v == 64'd0) ? 64'd1 : v;
  endfunction

  function automatic chs_t chs_of(logic [31:0] lba, logic [7:0] heads_r, logic [5:0] spt_r);
    logic [63:0] spt;
    logic [63:0] spc;
    logic [63:0] cyl;
    logic [63:0] head;
    logic [63:0] sect;
    chs_t        r;
    spt = nz(64'(spt_r));
    spc = nz(64'(heads_r)) * spt;
    cyl = 64'(lba) / spc;
    head = (64'(lba) % spc) / spt;
    sect = (64'(lba) % spt) + 64'd1;
    r.head = head[7:0];
    r.sect_cyl_hi = {cyl[9:8], sect[5:0]};
    r.cyl_lo = cyl[7:0];
    r.cyl = cyl[31:0];
    r.ovf = (cyl > CYL_PACKED_MAX);
    return r;
  endfunction

  function automatic logic [31:0] pick_lba();
    logic [63:0] spc;
    logic [63:0] wrap;
    logic [63:0] v;
    spc = nz(64'(head_count_q)) * nz(64'(spt_q));
    wrap = spc * (CYL_PACKED_MAX + 64'd1);
    case ($urandom_range(0, 4))
      0: v = 64'($urandom());
      1: v = wrap - spc + 64'($urandom_range(0, 2 * int'(spc)));
      2: v = 64'($urandom_range(0, int'(wrap)));
      3: v = ($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF : 64'd0;
      default: v = 64'($urandom()) >> $urandom_range(0, 31);
    endcase
    return v[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_lba(logic [31:0] lba, int idle_pct, chs_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    lba_i   <= lba;
    do @(posedge clk_i); while (busy_o);
    pending_chs.push_back(want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_HEAD_COUNT) begin
      head_count_q = data;
    end else if (idx == REG_SECTORS_PER_TRACK) begin
      spt_q = data[5:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_chs.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    chs_t want;
    if (rst_ni && valid_o) begin
      if (pending_chs.size() == 0) begin
        report_mismatch("unexpected result, cylinder", 64'(cylinder_o), 64'd0);
      end else begin
        want = pending_chs.pop_front();
        if (head_byte_o !== want.head)
          report_mismatch("head_byte", 64'(head_byte_o), 64'(want.head));
        if (sector_cyl_high_byte_o !== want.sect_cyl_hi)
          report_mismatch("sector_cyl_high_byte", 64'(sector_cyl_high_byte_o),
                          64'(want.sect_cyl_hi));
        if (cyl_low_byte_o !== want.cyl_lo)
          report_mismatch("cyl_low_byte", 64'(cyl_low_byte_o), 64'(want.cyl_lo));
        if (cylinder_o !== want.cyl)
          report_mismatch("cylinder", 64'(cylinder_o), 64'(want.cyl));
        if (cyl_overflow_o !== want.ovf)
          report_mismatch("cyl_overflow", 64'(cyl_overflow_o), 64'(want.ovf));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_chs.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] lba;
    int          idle_pct;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    lba_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_HEAD_COUNT;
    cfg_data_i   = '0;
    head_count_q = HEAD_RESET;
    spt_q        = SPT_RESET;
    mismatches   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
      end else begin
        send_lba(DIR_ROWS[i].lba, 0, DIR_ROWS[i].typed ? DIR_ROWS[i].want :
                 chs_of(DIR_ROWS[i].lba, head_count_q, spt_q));
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_HEAD_COUNT, 8'hFF);
          write_reg(REG_SECTORS_PER_TRACK, 8'h3F);
        end
        1: begin
          write_reg(REG_HEAD_COUNT, 8'h01);
          write_reg(REG_SECTORS_PER_TRACK, 8'h01);
        end
        2: begin
          write_reg(REG_HEAD_COUNT, 8'h00);
          write_reg(REG_SECTORS_PER_TRACK, 8'h00);
        end
        default: begin
          write_reg(REG_HEAD_COUNT, 8'($urandom_range(0, 255)));
          write_reg(REG_SECTORS_PER_TRACK, 8'($urandom_range(0, 255)));
          if (ph == 5) write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
        end
      endcase
      // sender gaps; receiver cannot stall so those phases run without gaps
      case (ph % 4)
        1:       idle_pct = 78;
        3:       idle_pct = 19;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        lba = pick_lba();
        send_lba(lba, idle_pct, chs_of(lba, head_count_q, spt_q));
      end
    end

    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_chs.size() != 0)
      report_mismatch("results never delivered", 64'(pending_chs.size()), 64'd0);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
